### design/hbf_pkg.sv
// shared types and constants for the harmonic bond force block
package hbf_pkg;

  localparam logic [31:0] UNIT2_Q16 = 32'd54841442;
  localparam logic [47:0] FMAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] FMIN_MAG = 48'h8000_0000_0000;
  localparam logic [47:0] EMAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [62:0] TMAX = {63{1'b1}};

  typedef struct packed {
    logic [15:0]       atom_a;
    logic [15:0]       atom_b;
    logic [2:0][32:0]  dmag;
    logic [2:0]        dneg;
    logic [31:0]       k;
    logic [31:0]       r0;
    logic              last;
  } hbf_item_t;

  typedef struct packed {
    logic [1:0] level;
    logic       full;
    logic       empty;
  } hbf_qstat_t;

endpackage

### design/harmonic_bond_force.sv
// top level of the harmonic bond stretch force block
// One bond per transfer in, one result per transfer out. A bond goes from the
// queue through the squares, the square root, the three shift-add product
// chains and the bit-serial force dividers to the output register; the engine
// takes the next bond from the queue only after the result is delivered. Two
// bonds can wait in the queue and a finished result waits in the output
// register while the next bond is computed. Force is saturated to 48 bits,
// energy to 48 and 63 bits; a zero length gives zero force with status 1. The
// energy total clears after a bond marked last.
module harmonic_bond_force (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_atom_a_number,
  input  logic [15:0]        in_atom_b_number,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  input  logic [31:0]        in_stiffness,
  input  logic [31:0]        in_rest_length,
  input  logic               in_last_in_set,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_atom_a,
  output logic [15:0]        out_atom_b,
  output logic signed [47:0] out_force_x,
  output logic signed [47:0] out_force_y,
  output logic signed [47:0] out_force_z,
  output logic [47:0]        out_energy_term,
  output logic [62:0]        out_energy_total,
  output logic               out_status
);
  import hbf_pkg::*;

  hbf_item_t  fe_item, q_head;
  hbf_qstat_t q_stat;
  logic       q_pop, q_push;

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  hbf_front u_front (
    .atom_a_number (in_atom_a_number),
    .atom_b_number (in_atom_b_number),
    .a_x           (in_a_x),
    .a_y           (in_a_y),
    .a_z           (in_a_z),
    .b_x           (in_b_x),
    .b_y           (in_b_y),
    .b_z           (in_b_z),
    .stiffness     (in_stiffness),
    .rest_length   (in_rest_length),
    .last_in_set   (in_last_in_set),
    .item          (fe_item)
  );

  hbf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (fe_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  hbf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (q_head),
    .head_valid   (!q_stat.empty),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_atom_a   (out_atom_a),
    .out_atom_b   (out_atom_b),
    .force_x      (out_force_x),
    .force_y      (out_force_y),
    .force_z      (out_force_z),
    .energy_term  (out_energy_term),
    .energy_total (out_energy_total),
    .status       (out_status)
  );

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> q_stat.level != 2'd0)
    else $error("queue empty after transfer in");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_force_x == '0 && out_force_y == '0 && out_force_z == '0)
    else $error("force not zero at zero length");

  a_total_ge_term: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_energy_total >= 63'(out_energy_term))
    else $error("energy total below term");

endmodule

### design/hbf_front.sv
// front end: forms the separation vector of each bond as magnitude and sign
module hbf_front (
  input  logic [15:0]        atom_a_number,
  input  logic [15:0]        atom_b_number,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  input  logic [31:0]        stiffness,
  input  logic [31:0]        rest_length,
  input  logic               last_in_set,
  output hbf_pkg::hbf_item_t item
);
  import hbf_pkg::*;

  logic signed [32:0] d [3];

  always_comb begin
    d[0] = 33'(b_x) - 33'(a_x);
    d[1] = 33'(b_y) - 33'(a_y);
    d[2] = 33'(b_z) - 33'(a_z);
    item.atom_a = atom_a_number;
    item.atom_b = atom_b_number;
    item.k      = stiffness;
    item.r0     = rest_length;
    item.last   = last_in_set;
    for (int j = 0; j < 3; j++) begin
      item.dneg[j] = d[j][32];
      item.dmag[j] = d[j][32] ? 33'(-d[j]) : 33'(d[j]);
    end
  end

endmodule

### design/hbf_queue.sv
// two-entry queue between front end and compute engine
module hbf_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hbf_pkg::hbf_item_t push_item,
  input  logic               pop,
  output hbf_pkg::hbf_item_t head,
  output hbf_pkg::hbf_qstat_t stat
);
  import hbf_pkg::*;

  hbf_item_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

  assign head       = mem_r[rp_r];
  assign stat.level = cnt_r;
  assign stat.full  = cnt_r == 2'd2;
  assign stat.empty = cnt_r == 2'd0;

endmodule

### design/hbf_back.sv
// compute engine: length, energy and force by sequential shift-add and digit loops
module hbf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  hbf_pkg::hbf_item_t head,
  input  logic               head_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_atom_a,
  output logic [15:0]        out_atom_b,
  output logic signed [47:0] force_x,
  output logic signed [47:0] force_y,
  output logic signed [47:0] force_z,
  output logic [47:0]        energy_term,
  output logic [62:0]        energy_total,
  output logic               status
);
  import hbf_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_SUM  = 4'd2;
  localparam logic [3:0] S_SQRT = 4'd3;
  localparam logic [3:0] S_EM   = 4'd4;
  localparam logic [3:0] S_MUL1 = 4'd5;
  localparam logic [3:0] S_MUL2 = 4'd6;
  localparam logic [3:0] S_MUL3 = 4'd7;
  localparam logic [3:0] S_LDD  = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]   state_r, state_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  hbf_item_t    item_r, item_nxt;
  logic [65:0]  sq_r [3];
  logic [65:0]  sq_nxt [3];
  logic [65:0]  s_r, s_nxt;
  logic [33:0]  rem_r, rem_nxt;
  logic [32:0]  root_r, root_nxt;
  logic [32:0]  em_r, em_nxt;
  logic         eneg_r, eneg_nxt;
  logic [64:0]  p_r, p_nxt;
  logic [65:0]  e1_r, e1_nxt;
  logic [90:0]  base_r, base_nxt;
  logic [97:0]  t_r, t_nxt;
  logic [123:0] m_r [3];
  logic [123:0] m_nxt [3];
  logic [91:0]  w_r [3];
  logic [91:0]  w_nxt [3];
  logic [32:0]  dr_r [3];
  logic [32:0]  dr_nxt [3];
  logic [62:0]  esum_r, esum_nxt;
  logic         ov_r, ov_nxt;

  logic [35:0]  rem_sh, trial;
  logic [33:0]  dsh [3];
  logic [47:0]  fmag [3];
  logic [47:0]  fval [3];
  logic [47:0]  lim;
  logic         fneg;
  logic [47:0]  term;
  logic [63:0]  tot;
  logic [62:0]  tot_sat;
  logic         deliver;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    item_nxt  = item_r;
    s_nxt     = s_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    em_nxt    = em_r;
    eneg_nxt  = eneg_r;
    p_nxt     = p_r;
    e1_nxt    = e1_r;
    base_nxt  = base_r;
    t_nxt     = t_r;
    esum_nxt  = esum_r;
    ov_nxt    = ov_r;
    pop       = 1'b0;
    deliver   = 1'b0;
    rem_sh    = {rem_r, s_r[65:64]};
    trial     = {1'b0, root_r, 2'b01};
    for (int j = 0; j < 3; j++) begin
      sq_nxt[j] = sq_r[j];
      m_nxt[j]  = m_r[j];
      w_nxt[j]  = w_r[j];
      dr_nxt[j] = dr_r[j];
      dsh[j]    = {dr_r[j], w_r[j][91]};
      lim       = '0;
      fneg      = eneg_r ^ item_r.dneg[j];
      lim       = fneg ? FMIN_MAG : FMAX;
      fmag[j]   = (w_r[j] > 92'(lim)) ? lim : w_r[j][47:0];
      fval[j]   = (root_r == '0) ? '0 : (fneg ? 48'(-fmag[j]) : fmag[j]);
    end
    fneg    = 1'b0;
    lim     = '0;
    term    = (|t_r[97:80]) ? EMAX : t_r[79:32];
    tot     = {1'b0, esum_r} + 64'(term);
    tot_sat = tot[63] ? TMAX : tot[62:0];
    if (ov_r && !out_stall) ov_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (head_valid) begin
          pop       = 1'b1;
          item_nxt  = head;
          cnt_nxt   = 7'd32;
          state_nxt = S_SQ;
          for (int j = 0; j < 3; j++) sq_nxt[j] = '0;
        end
      end
      S_SQ: begin
        for (int j = 0; j < 3; j++)
          sq_nxt[j] = {sq_r[j][64:0], 1'b0}
                    + (item_r.dmag[j][cnt_r[5:0]] ? 66'(item_r.dmag[j]) : 66'd0);
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == '0) state_nxt = S_SUM;
      end
      S_SUM: begin
        s_nxt     = sq_r[0] + sq_r[1] + sq_r[2];
        rem_nxt   = '0;
        root_nxt  = '0;
        cnt_nxt   = 7'd32;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (rem_sh >= trial) begin
          rem_nxt  = 34'(rem_sh - trial);
          root_nxt = {root_r[31:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh[33:0];
          root_nxt = {root_r[31:0], 1'b0};
        end
        s_nxt   = {s_r[63:0], 2'b00};
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == '0) state_nxt = S_EM;
      end
      S_EM: begin
        eneg_nxt  = root_r < {1'b0, item_r.r0};
        em_nxt    = eneg_nxt ? ({1'b0, item_r.r0} - root_r) : (root_r - {1'b0, item_r.r0});
        p_nxt     = '0;
        e1_nxt    = '0;
        cnt_nxt   = 7'd32;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        p_nxt   = {p_r[63:0], 1'b0} + (em_r[cnt_r[5:0]] ? 65'(item_r.k) : 65'd0);
        e1_nxt  = {e1_r[64:0], 1'b0} + (em_r[cnt_r[5:0]] ? 66'(em_r) : 66'd0);
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == '0) begin
          base_nxt  = '0;
          t_nxt     = '0;
          cnt_nxt   = 7'd31;
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        base_nxt = {base_r[89:0], 1'b0} + (UNIT2_Q16[cnt_r[4:0]] ? 91'(p_r) : 91'd0);
        t_nxt    = {t_r[96:0], 1'b0} + (item_r.k[cnt_r[4:0]] ? 98'(e1_r) : 98'd0);
        cnt_nxt  = cnt_r - 7'd1;
        if (cnt_r == '0) begin
          for (int j = 0; j < 3; j++) m_nxt[j] = '0;
          cnt_nxt   = 7'd32;
          state_nxt = S_MUL3;
        end
      end
      S_MUL3: begin
        for (int j = 0; j < 3; j++)
          m_nxt[j] = {m_r[j][122:0], 1'b0}
                   + (item_r.dmag[j][cnt_r[5:0]] ? 124'(base_r) : 124'd0);
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == '0) state_nxt = (root_r == '0) ? S_DONE : S_LDD;
      end
      S_LDD: begin
        for (int j = 0; j < 3; j++) begin
          w_nxt[j]  = m_r[j][123:32];
          dr_nxt[j] = '0;
        end
        cnt_nxt   = 7'd91;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        for (int j = 0; j < 3; j++) begin
          if (dsh[j] >= {1'b0, root_r}) begin
            dr_nxt[j] = 33'(dsh[j] - {1'b0, root_r});
            w_nxt[j]  = {w_r[j][90:0], 1'b1};
          end else begin
            dr_nxt[j] = dsh[j][32:0];
            w_nxt[j]  = {w_r[j][90:0], 1'b0};
          end
        end
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == '0) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          deliver   = 1'b1;
          ov_nxt    = 1'b1;
          esum_nxt  = item_r.last ? '0 : tot_sat;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      esum_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      esum_r  <= esum_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    item_r <= item_nxt;
    s_r    <= s_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    em_r   <= em_nxt;
    eneg_r <= eneg_nxt;
    p_r    <= p_nxt;
    e1_r   <= e1_nxt;
    base_r <= base_nxt;
    t_r    <= t_nxt;
    for (int j = 0; j < 3; j++) begin
      sq_r[j] <= sq_nxt[j];
      m_r[j]  <= m_nxt[j];
      w_r[j]  <= w_nxt[j];
      dr_r[j] <= dr_nxt[j];
    end
    if (deliver) begin
      out_atom_a   <= item_r.atom_a;
      out_atom_b   <= item_r.atom_b;
      force_x      <= fval[0];
      force_y      <= fval[1];
      force_z      <= fval[2];
      energy_term  <= term;
      energy_total <= tot_sat;
      status       <= root_r == '0;
    end
  end

  assign out_valid = ov_r;

endmodule
